@@ rtl/thc_pkg.sv @@
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types, constants and a digit helper for the twelve-hour clock.
// ----------------------------------------------------------------------------
package thc_pkg;

  localparam int unsigned StampW    = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned HourW     = 5;  // 0..23
  localparam int unsigned MinuteW   = 6;  // 0..59

  localparam logic [DebounceW-1:0] DebounceReset = 16'd1000;
  localparam logic [HourW-1:0]     LastHour      = 5'd23;
  localparam logic [HourW-1:0]     NoonHour      = 5'd12;
  localparam logic [MinuteW-1:0]   LastMinute    = 6'd59;

  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdMinBtn  = 2'd1,
    CmdHourBtn = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  // Result of one button edge against its debounce window.
  typedef struct packed {
    logic counted;  // edge is outside the debounce gap
    logic press;    // counted edge that found the button released
  } edge_status_t;

  // Display digits of one time value.
  typedef struct packed {
    logic       hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic       is_pm;
  } disp_t;

  // Tens digit of a value 0..63 by comparison against the decade bounds.
  function automatic logic [2:0] tens_of(input logic [MinuteW-1:0] v);
    logic [2:0] t;
    if (v >= 6'd60) begin
      t = 3'd6;
    end else if (v >= 6'd50) begin
      t = 3'd5;
    end else if (v >= 6'd40) begin
      t = 3'd4;
    end else if (v >= 6'd30) begin
      t = 3'd3;
    end else if (v >= 6'd20) begin
      t = 3'd2;
    end else if (v >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    return t;
  endfunction

endpackage

@@ rtl/twelve_hour_clock_with_set_buttons.sv @@
// ----------------------------------------------------------------------------
// twelve_hour_clock_with_set_buttons
// Minute-of-day clock with debounced minute and hour set buttons.
// An accepted event passes the input register and then the result register.
// Throughput: one event per cycle; the input register and result register
// hand off every cycle unless the result waits under stall.
// Reset clears the time to 12:00 AM, both buttons to released with last
// edge at zero, and the debounce gap to 1000.
// ----------------------------------------------------------------------------
module twelve_hour_clock_with_set_buttons (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] edge_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hour_tens_o,
  output logic [3:0]  hour_ones_o,
  output logic [2:0]  minute_tens_o,
  output logic [3:0]  minute_ones_o,
  output logic        is_pm_o,
  output logic        display_update_o
);

  logic [thc_pkg::DebounceW-1:0] debounce_q;

  logic                          in_valid_q;
  thc_pkg::cmd_e                 cmd_q;
  logic [thc_pkg::StampW-1:0]    stamp_q;

  logic [thc_pkg::HourW-1:0]     hour_q, hour_d;
  logic [thc_pkg::MinuteW-1:0]   minute_q, minute_d;

  logic                          out_valid_q;
  thc_pkg::disp_t                disp_q;
  logic                          update_q;

  logic                          accept;
  logic                          fire;
  logic                          min_edge, hour_edge;
  thc_pkg::edge_status_t         min_status, hour_status;
  logic                          add_minute, add_hour;
  thc_pkg::disp_t                disp_d;

  // The held item moves on whenever the result register is free or drains.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign min_edge  = fire && (cmd_q == thc_pkg::CmdMinBtn);
  assign hour_edge = fire && (cmd_q == thc_pkg::CmdHourBtn);

  thc_debounce u_min_btn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_i     (min_edge),
    .stamp_i    (stamp_q),
    .debounce_i (debounce_q),
    .status_o   (min_status)
  );

  thc_debounce u_hour_btn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_i     (hour_edge),
    .stamp_i    (stamp_q),
    .debounce_i (debounce_q),
    .status_o   (hour_status)
  );

  always_comb begin
    add_minute = 1'b0;
    add_hour   = 1'b0;
    case (cmd_q)
      thc_pkg::CmdTick:    add_minute = 1'b1;
      thc_pkg::CmdMinBtn:  add_minute = min_status.press;
      thc_pkg::CmdHourBtn: add_hour   = hour_status.press;
      default:             ;
    endcase
  end

  // Next time value; a minute carry and an hour press both step the hour.
  always_comb begin
    hour_d   = hour_q;
    minute_d = minute_q;
    if (add_minute) begin
      if (minute_q == thc_pkg::LastMinute) begin
        minute_d = '0;
        hour_d   = (hour_q == thc_pkg::LastHour) ? '0 : hour_q + 5'd1;
      end else begin
        minute_d = minute_q + 6'd1;
      end
    end else if (add_hour) begin
      hour_d = (hour_q == thc_pkg::LastHour) ? '0 : hour_q + 5'd1;
    end
  end

  thc_fmt u_fmt (
    .hour_i   (hour_d),
    .minute_i (minute_d),
    .disp_o   (disp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= thc_pkg::DebounceReset;
      in_valid_q  <= 1'b0;
      hour_q      <= '0;
      minute_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        debounce_q <= cfg_wdata_i;
      end
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        hour_q      <= hour_d;
        minute_q    <= minute_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= thc_pkg::cmd_e'(cmd_i);
      stamp_q <= edge_time_i;
    end
    if (fire) begin
      disp_q   <= disp_d;
      update_q <= add_minute || add_hour;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hour_tens_o      = disp_q.hour_tens;
  assign hour_ones_o      = disp_q.hour_ones;
  assign minute_tens_o    = disp_q.minute_tens;
  assign minute_ones_o    = disp_q.minute_ones;
  assign is_pm_o          = disp_q.is_pm;
  assign display_update_o = update_q;

endmodule

@@ rtl/thc_debounce.sv @@
// ----------------------------------------------------------------------------
// thc_debounce
// Debounce window and pressed flag of one set button.
// ----------------------------------------------------------------------------
module thc_debounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           edge_i,     // edge of this button is processed
  input  logic [thc_pkg::StampW-1:0]     stamp_i,
  input  logic [thc_pkg::DebounceW-1:0]  debounce_i,
  output thc_pkg::edge_status_t          status_o
);

  logic [thc_pkg::StampW-1:0] last_q, last_d;
  logic                       down_q, down_d;
  logic [thc_pkg::StampW-1:0] gap;

  // The subtraction wraps with the free-running timestamp.
  assign gap = stamp_i - last_q;

  always_comb begin
    status_o.counted = gap > thc_pkg::StampW'(debounce_i);
    status_o.press   = status_o.counted && !down_q;
    last_d = last_q;
    down_d = down_q;
    if (edge_i && status_o.counted) begin
      last_d = stamp_i;
      down_d = !down_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      down_q <= 1'b0;
    end else begin
      last_q <= last_d;
      down_q <= down_d;
    end
  end

endmodule

@@ rtl/thc_fmt.sv @@
// ----------------------------------------------------------------------------
// thc_fmt
// Converts a 24-hour time into 12-hour BCD digits and the AM/PM flag.
// ----------------------------------------------------------------------------
module thc_fmt (
  input  logic [thc_pkg::HourW-1:0]   hour_i,
  input  logic [thc_pkg::MinuteW-1:0] minute_i,
  output thc_pkg::disp_t              disp_o
);

  logic [thc_pkg::HourW-1:0]   hour12;
  logic [2:0]                  min_tens;
  logic [thc_pkg::MinuteW-1:0] min_ones;

  always_comb begin
    disp_o.is_pm = hour_i >= thc_pkg::NoonHour;
    hour12 = disp_o.is_pm ? hour_i - thc_pkg::NoonHour : hour_i;
    // Hour zero of each half day reads as twelve.
    if (hour12 == '0) begin
      hour12 = thc_pkg::NoonHour;
    end
    disp_o.hour_tens = hour12 >= 5'd10;
    disp_o.hour_ones = disp_o.hour_tens ? 4'(hour12 - 5'd10) : 4'(hour12);

    min_tens = thc_pkg::tens_of(minute_i);
    min_ones = minute_i - thc_pkg::MinuteW'(min_tens) * 6'd10;
    disp_o.minute_tens = min_tens;
    disp_o.minute_ones = min_ones[3:0];
  end

endmodule

@@ rtl/thc_checker.sv @@
// ----------------------------------------------------------------------------
// thc_checker
// Port-level checks of the twelve-hour clock, bound to the top level.
// ----------------------------------------------------------------------------
module thc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hour_tens_o,
  input logic [3:0]  hour_ones_o,
  input logic [2:0]  minute_tens_o,
  input logic [3:0]  minute_ones_o,
  input logic        is_pm_o,
  input logic        display_update_o
);

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hour_tens_o) &&
      $stable(hour_ones_o) && $stable(minute_tens_o) && $stable(minute_ones_o) &&
      $stable(is_pm_o) && $stable(display_update_o))
    else $error("stalled result changed");

  // The input side backs up only behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result register can move");

  // The hour reads 1..12.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_tens_o && hour_ones_o <= 4'd2) ||
      (!hour_tens_o && hour_ones_o != 4'd0 && hour_ones_o <= 4'd9))
    else $error("hour digits out of range");

  // The minute reads 00..59.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> minute_tens_o <= 3'd5 && minute_ones_o <= 4'd9)
    else $error("minute digits out of range");

endmodule

bind twelve_hour_clock_with_set_buttons thc_checker u_thc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .hour_tens_o      (hour_tens_o),
  .hour_ones_o      (hour_ones_o),
  .minute_tens_o    (minute_tens_o),
  .minute_ones_o    (minute_ones_o),
  .is_pm_o          (is_pm_o),
  .display_update_o (display_update_o)
);
